@@ hw/rtl/slt_pkg.sv @@
`default_nettype none
package slt_pkg;

  localparam int unsigned POS_BITS_DEF  = 24;
  localparam int unsigned LINE_BITS_DEF = 16;
  localparam int unsigned OFF_W         = 24;
  localparam int unsigned LN_W          = 16;
  localparam int unsigned MAX_RES       = 4;

  // lexer modes
  localparam logic [4:0] M_IDLE = 5'd0,  M_SLASH = 5'd1,  M_COMMENT = 5'd2,
                         M_DOT = 5'd3,   M_NUM_FIRST = 5'd4, M_INT = 5'd5,
                         M_INT_DOT = 5'd6, M_FRAC = 5'd7, M_EXP_SIGN = 5'd8,
                         M_EXP_AFTER_SIGN = 5'd9, M_EXP_DIGITS = 5'd10,
                         M_HEX_FIRST = 5'd11, M_HEX = 5'd12, M_BIN_FIRST = 5'd13,
                         M_BIN = 5'd14, M_IDENT = 5'd15, M_Q1 = 5'd16, M_Q2 = 5'd17,
                         M_STR = 5'd18, M_STR_ESC = 5'd19, M_LONG = 5'd20,
                         M_LONG_Q1 = 5'd21, M_LONG_Q2 = 5'd22;

  localparam logic [4:0] T_DOT = 5'd15, T_RANGE = 5'd16, T_INT = 5'd17, T_HEX = 5'd18,
                         T_BIN = 5'd19, T_FLOAT = 5'd20, T_IDENT = 5'd21,
                         T_STRING = 5'd22, T_LONG_STRING = 5'd23, T_END = 5'd24;

  localparam logic [2:0] E_NO_HEX = 3'd0, E_NO_BIN = 3'd1, E_LEAD_ZERO = 3'd2,
                         E_NO_EXP = 3'd3, E_BAD_ESC = 3'd4, E_UNTERM_STR = 3'd5,
                         E_UNTERM_LONG = 3'd6, E_UNEXPECTED = 3'd7;

  localparam logic K_TOKEN = 1'b0;
  localparam logic K_ERROR = 1'b1;
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_req;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [4:0]        token_type;
    logic [2:0]        error_code;
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  length;
    logic [LN_W-1:0]   line;
    logic [7:0]        bad_char;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic kind, logic [4:0] ttype, logic [2:0] code,
                                  logic [OFF_W-1:0] off, logic [OFF_W-1:0] len,
                                  logic [LN_W-1:0] ln, logic [7:0] bad);
    res_t r;
    r.kind       = kind;
    r.token_type = ttype;
    r.error_code = code;
    r.offset     = off;
    r.length     = len;
    r.line       = ln;
    r.bad_char   = bad;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_head(logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == 8'h0d || c == 8'h0a || c == 8'h09;
  endfunction

  // punctuation lookup: bit 5 = hit, [4:0] = token type
  function automatic logic [5:0] punct(logic [7:0] c);
    logic [5:0] r;
    r = '0;
    case (c)
      ",": r = {1'b1, 5'd0};
      "=": r = {1'b1, 5'd1};
      ";": r = {1'b1, 5'd2};
      ":": r = {1'b1, 5'd3};
      "-": r = {1'b1, 5'd4};
      "#": r = {1'b1, 5'd5};
      "@": r = {1'b1, 5'd6};
      "*": r = {1'b1, 5'd7};
      "?": r = {1'b1, 5'd8};
      "{": r = {1'b1, 5'd9};
      "}": r = {1'b1, 5'd10};
      "[": r = {1'b1, 5'd11};
      "]": r = {1'b1, 5'd12};
      "(": r = {1'b1, 5'd13};
      ")": r = {1'b1, 5'd14};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/slt_lexer.sv @@
`default_nettype none
module slt_lexer #(
  parameter int unsigned POS_BITS  = slt_pkg::POS_BITS_DEF,
  parameter int unsigned LINE_BITS = slt_pkg::LINE_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire slt_pkg::req_t req_i,
  output slt_pkg::res_t     res_o [slt_pkg::MAX_RES],
  output logic [2:0]        cnt_o
);
  import slt_pkg::*;

  typedef struct packed {
    logic [4:0]           mode;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  pos;
    logic [POS_BITS-1:0]  tstart;
    logic [LINE_BITS-1:0] sline;
    logic                 fz;
    logic                 halted;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic done;
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } pass_t;

  localparam st_t ST_RST = '{mode: M_IDLE, line: LINE_BITS'(1), pos: '0, tstart: '0,
                             sline: LINE_BITS'(1), fz: 1'b0, halted: 1'b0};

  st_t st_q, st_d;

  function automatic st_t adv(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if (c == 8'h0a) r.line = s.line + LINE_BITS'(1);
    r.pos = s.pos + POS_BITS'(1);
    return r;
  endfunction

  function automatic res_t tok(st_t s, logic [4:0] ty, logic [POS_BITS-1:0] len);
    return mk_res(K_TOKEN, ty, '0, OFF_W'(s.tstart), OFF_W'(len), LN_W'(s.line), 8'd0);
  endfunction

  function automatic res_t err(st_t s, logic [2:0] code, logic [POS_BITS-1:0] off,
                               logic [7:0] bad);
    return mk_res(K_ERROR, 5'd0, code, OFF_W'(off), '0, LN_W'(s.line), bad);
  endfunction

  function automatic pass_t lex_pass(st_t s, logic [7:0] c);
    pass_t p;
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] dot;
    logic [5:0] pc;
    p = '0;
    p.st = s;
    span = s.pos - s.tstart;
    dot  = s.pos - POS_BITS'(1);
    pc   = punct(c);
    case (s.mode)
      M_IDLE: begin
        p.done = 1'b1;
        if (!is_space(c)) begin
          p.st.tstart = s.pos;
          if (pc[5]) begin
            p.v0 = 1'b1; p.r0 = tok(p.st, pc[4:0], POS_BITS'(1));
          end else if (c == "/") p.st.mode = M_SLASH;
          else if (c == ".") p.st.mode = M_DOT;
          else if (is_digit(c)) begin
            p.st.fz = (c == "0"); p.st.mode = M_NUM_FIRST;
          end else if (is_head(c)) p.st.mode = M_IDENT;
          else if (c == "\"") p.st.mode = M_Q1;
          else begin
            p.v0 = 1'b1; p.r0 = err(s, E_UNEXPECTED, s.pos, c);
          end
        end
        p.st = adv(p.st, c);
      end
      M_SLASH: begin
        if (c == "/") begin
          p.st.mode = M_COMMENT; p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = 1'b1; p.r0 = err(s, E_UNEXPECTED, s.tstart, "/");
          p.st.mode = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (c == 8'h0a) p.st.mode = M_IDLE;
        p.st = adv(p.st, c); p.done = 1'b1;
      end
      M_DOT: begin
        if (c == ".") begin
          p.v0 = 1'b1; p.r0 = tok(s, T_RANGE, POS_BITS'(2));
          p.st.mode = M_IDLE; p.st = adv(p.st, c); p.done = 1'b1;
        end else if (is_digit(c)) begin
          p.st.mode = M_FRAC; p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_DOT, POS_BITS'(1)); p.st.mode = M_IDLE;
        end
      end
      M_NUM_FIRST: begin
        p.st.mode = M_INT;
        if (s.fz && c == "x") begin
          p.st.mode = M_HEX_FIRST; p.st = adv(p.st, c); p.done = 1'b1;
        end else if (s.fz && c == "b") begin
          p.st.mode = M_BIN_FIRST; p.st = adv(p.st, c); p.done = 1'b1;
        end else if (s.fz && is_digit(c)) begin
          p.v0 = 1'b1; p.r0 = err(s, E_LEAD_ZERO, s.tstart, 8'd0);
          p.st = adv(p.st, c); p.done = 1'b1;
        end
      end
      M_INT: begin
        p.done = 1'b1;
        if (is_digit(c)) p.st = adv(p.st, c);
        else if (c == ".") begin
          p.st.mode = M_INT_DOT; p.st = adv(p.st, c);
        end else if (c == "e" || c == "E") begin
          p.st.mode = M_EXP_SIGN; p.st = adv(p.st, c);
        end else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_INT, span); p.st.mode = M_IDLE; p.done = 1'b0;
        end
      end
      M_INT_DOT: begin
        if (c == ".") begin
          p.v0 = 1'b1; p.r0 = tok(s, T_INT, dot - s.tstart);
          p.v1 = 1'b1;
          p.r1 = mk_res(K_TOKEN, T_RANGE, '0, OFF_W'(dot), OFF_W'(2), LN_W'(s.line), 8'd0);
          p.st.mode = M_IDLE; p.st = adv(p.st, c); p.done = 1'b1;
        end else p.st.mode = M_FRAC;
      end
      M_FRAC, M_EXP_DIGITS: begin
        p.done = 1'b1;
        if (is_digit(c)) p.st = adv(p.st, c);
        else if (s.mode == M_FRAC && (c == "e" || c == "E")) begin
          p.st.mode = M_EXP_SIGN; p.st = adv(p.st, c);
        end else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_FLOAT, span); p.st.mode = M_IDLE; p.done = 1'b0;
        end
      end
      M_EXP_SIGN, M_EXP_AFTER_SIGN: begin
        p.done = 1'b1;
        if (s.mode == M_EXP_SIGN && (c == "+" || c == "-")) begin
          p.st.mode = M_EXP_AFTER_SIGN; p.st = adv(p.st, c);
        end else if (is_digit(c)) begin
          p.st.mode = M_EXP_DIGITS; p.st = adv(p.st, c);
        end else begin
          p.v0 = 1'b1; p.r0 = err(s, E_NO_EXP, s.tstart, 8'd0);
          p.v1 = 1'b1; p.r1 = tok(s, T_FLOAT, span);
          p.st.mode = M_IDLE; p.done = 1'b0;
        end
      end
      M_HEX_FIRST, M_HEX: begin
        if (is_hex(c)) begin
          p.st.mode = M_HEX; p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = (s.mode == M_HEX_FIRST); p.r0 = err(s, E_NO_HEX, s.tstart, 8'd0);
          p.v1 = 1'b1; p.r1 = tok(s, T_HEX, span); p.st.mode = M_IDLE;
        end
      end
      M_BIN_FIRST, M_BIN: begin
        if (c == "0" || c == "1") begin
          p.st.mode = M_BIN; p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = (s.mode == M_BIN_FIRST); p.r0 = err(s, E_NO_BIN, s.tstart, 8'd0);
          p.v1 = 1'b1; p.r1 = tok(s, T_BIN, span); p.st.mode = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_head(c) || is_digit(c)) begin
          p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_IDENT, span); p.st.mode = M_IDLE;
        end
      end
      M_Q1: begin
        if (c == "\"") begin
          p.st.mode = M_Q2; p.st = adv(p.st, c); p.done = 1'b1;
        end else p.st.mode = M_STR;
      end
      M_Q2: begin
        if (c == "\"") begin
          p.st.sline = s.line; p.st.mode = M_LONG; p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_STRING, POS_BITS'(2)); p.st.mode = M_IDLE;
        end
      end
      M_STR: begin
        p.done = 1'b1;
        if (c == "\"") begin
          p.v0 = 1'b1; p.r0 = tok(s, T_STRING, span + POS_BITS'(1));
          p.st.mode = M_IDLE; p.st = adv(p.st, c);
        end else if (c == "\\") begin
          p.st.mode = M_STR_ESC; p.st = adv(p.st, c);
        end else if (c == 8'h0a) begin
          p.v0 = 1'b1; p.r0 = err(s, E_UNTERM_STR, s.tstart, 8'd0); p.st.halted = 1'b1;
        end else p.st = adv(p.st, c);
      end
      M_STR_ESC: begin
        p.st.mode = M_STR;
        if (c == "\\" || c == "n") begin
          p.st = adv(p.st, c); p.done = 1'b1;
        end else begin
          p.v0 = 1'b1; p.r0 = err(s, E_BAD_ESC, s.pos, c);
        end
      end
      M_LONG, M_LONG_Q1, M_LONG_Q2: begin
        p.done = 1'b1;
        if (c != "\"") p.st.mode = M_LONG;
        else if (s.mode == M_LONG) p.st.mode = M_LONG_Q1;
        else if (s.mode == M_LONG_Q1) p.st.mode = M_LONG_Q2;
        else begin
          p.v0 = 1'b1; p.r0 = tok(s, T_LONG_STRING, span + POS_BITS'(1));
          p.st.mode = M_IDLE;
        end
        p.st = adv(p.st, c);
      end
      default: p.st.mode = M_IDLE;
    endcase
    return p;
  endfunction

  // pending-token closure at the end marker
  function automatic pass_t flush(st_t s);
    pass_t p;
    logic [POS_BITS-1:0] span;
    p = '0;
    p.st = s;
    span = s.pos - s.tstart;
    case (s.mode)
      M_SLASH: begin p.v0 = 1'b1; p.r0 = err(s, E_UNEXPECTED, s.tstart, "/"); end
      M_DOT: begin p.v0 = 1'b1; p.r0 = tok(s, T_DOT, POS_BITS'(1)); end
      M_NUM_FIRST, M_INT: begin p.v0 = 1'b1; p.r0 = tok(s, T_INT, span); end
      M_INT_DOT, M_FRAC, M_EXP_DIGITS: begin p.v0 = 1'b1; p.r0 = tok(s, T_FLOAT, span); end
      M_EXP_SIGN, M_EXP_AFTER_SIGN: begin
        p.v0 = 1'b1; p.r0 = err(s, E_NO_EXP, s.tstart, 8'd0);
        p.v1 = 1'b1; p.r1 = tok(s, T_FLOAT, span);
      end
      M_HEX_FIRST, M_HEX: begin
        p.v0 = (s.mode == M_HEX_FIRST); p.r0 = err(s, E_NO_HEX, s.tstart, 8'd0);
        p.v1 = 1'b1; p.r1 = tok(s, T_HEX, span);
      end
      M_BIN_FIRST, M_BIN: begin
        p.v0 = (s.mode == M_BIN_FIRST); p.r0 = err(s, E_NO_BIN, s.tstart, 8'd0);
        p.v1 = 1'b1; p.r1 = tok(s, T_BIN, span);
      end
      M_IDENT: begin p.v0 = 1'b1; p.r0 = tok(s, T_IDENT, span); end
      M_Q1, M_STR, M_STR_ESC: begin
        p.v0 = 1'b1; p.r0 = err(s, E_UNTERM_STR, s.tstart, 8'd0);
      end
      M_Q2: begin p.v0 = 1'b1; p.r0 = tok(s, T_STRING, POS_BITS'(2)); end
      M_LONG, M_LONG_Q1, M_LONG_Q2: begin
        p.v0 = 1'b1;
        p.r0 = mk_res(K_ERROR, 5'd0, E_UNTERM_LONG, OFF_W'(s.tstart), '0,
                      LN_W'(s.sline), 8'd0);
        p.v1 = 1'b1; p.r1 = tok(s, T_LONG_STRING, span);
      end
      default: p = p;
    endcase
    return p;
  endfunction

  always_comb begin
    pass_t      p;
    st_t        s;
    logic [2:0] n;
    logic       stop;
    s = st_q;
    n = '0;
    stop = 1'b0;
    p = '0;
    for (int i = 0; i < MAX_RES; i++) res_o[i] = '0;
    if (req_i.cmd != CMD_BYTE) begin
      if (!s.halted) begin
        p = flush(s);
        if (p.v0) begin res_o[n[1:0]] = p.r0; n = n + 3'd1; end
        if (p.v1) begin res_o[n[1:0]] = p.r1; n = n + 3'd1; end
      end
      res_o[n[1:0]] = mk_res(K_TOKEN, T_END, '0, OFF_W'(s.pos), '0, LN_W'(s.line), 8'd0);
      n = n + 3'd1;
      s = ST_RST;
    end else if (!s.halted) begin
      // up to four passes over the same byte, re-lexing after a token closes
      for (int k = 0; k < MAX_RES; k++) begin
        if (!stop) begin
          p = lex_pass(s, req_i.byte_req);
          s = p.st;
          if (p.v0 && n < 3'd4) begin res_o[n[1:0]] = p.r0; n = n + 3'd1; end
          if (p.v1 && n < 3'd4) begin res_o[n[1:0]] = p.r1; n = n + 3'd1; end
          stop = p.done || s.halted;
        end
      end
    end
    st_d  = s;
    cnt_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RST;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/schema_language_tokenizer_core.sv @@
`default_nettype none
// Channel | Dir | Handshake                   | Payload
// in      | in  | in_valid_i / in_ready_o     | in_req_i  (cmd, byte_req)
// out     | out | out_valid_o / out_ready_i   | out_res_o (token or error report)
//
// One request per cycle while the buffer is free: the byte sits in an input
// register, the combinational lexer logic drops its results (up to four) into
// a result buffer. Requests that make zero or one result flow at one per cycle
// while the output is ready; a larger burst holds the input side while the buffer drains.
// Reset puts the lexer idle at line one, position zero, buffer empty.
// A stalled output keeps the current result and holds back the input register.
module schema_language_tokenizer_core #(
  parameter int unsigned POS_BITS  = slt_pkg::POS_BITS_DEF,
  parameter int unsigned LINE_BITS = slt_pkg::LINE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire slt_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output slt_pkg::res_t      out_res_o
);
  import slt_pkg::*;

  // input register
  logic in_valid_q;
  req_t in_q;

  // result buffer: rem_q results left, idx_q the next one to send
  res_t       buf_q [MAX_RES];
  logic [2:0] rem_q;
  logic [1:0] idx_q;

  res_t       lex_res [MAX_RES];
  logic [2:0] lex_cnt;
  logic       buf_free;
  logic       step;
  logic       out_fire;

  assign out_fire    = out_valid_o && out_ready_i;
  // buffer can take a new burst when empty or once its last result leaves this cycle
  assign buf_free    = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready_i);
  assign step        = in_valid_q && buf_free;
  assign in_ready_o  = !in_valid_q || step;

  slt_lexer #(
    .POS_BITS (POS_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .req_i (in_q),
    .res_o (lex_res),
    .cnt_o (lex_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (step) begin
      rem_q <= lex_cnt;
      idx_q <= '0;
    end else if (out_fire) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      buf_q <= lex_res;
    end
  end

  // last result of a burst is the one with a single entry left
  always_comb begin
    out_res_o      = buf_q[idx_q];
    out_res_o.last = (rem_q == 3'd1);
  end

  assign out_valid_o = (rem_q != 3'd0);

endmodule
`default_nettype wire

@@ tb/schema_language_tokenizer_checker.sv @@
`timescale 1ns / 1ps
module schema_language_tokenizer_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire slt_pkg::req_t in_req_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  wire slt_pkg::res_t out_res_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import slt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SLASH, S_COMMENT, S_DOT, S_NUM_FIRST, S_INT, S_INT_DOT, S_FRAC,
    S_EXP_SIGN, S_EXP_AFTER_SIGN, S_EXP_DIGITS, S_HEX_FIRST, S_HEX, S_BIN_FIRST,
    S_BIN, S_IDENT, S_Q1, S_Q2, S_STR, S_STR_ESC, S_LONG, S_LONG_Q1, S_LONG_Q2
  } lex_state_e;

  lex_state_e       st;
  logic [LN_W-1:0]  ln_cnt, str_line;
  logic [OFF_W-1:0] pos, tok_start;
  logic             lead_zero, stopped;
  res_t             tokens_q[$];
  res_t             burst[$];

  assign pending_o = tokens_q.size();

  function automatic logic dig(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic hexd(logic [7:0] c);
    return dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic head(logic [7:0] c);
    return c == 8'h5f || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic wsp(logic [7:0] c);
    return c == 8'h20 || c == 8'h0d || c == 8'h0a || c == 8'h09;
  endfunction

  function automatic int punct_idx(logic [7:0] c);
    case (c)
      8'h2c: return 0;  8'h3d: return 1;  8'h3b: return 2;  8'h3a: return 3;
      8'h2d: return 4;  8'h23: return 5;  8'h40: return 6;  8'h2a: return 7;
      8'h3f: return 8;  8'h7b: return 9;  8'h7d: return 10; 8'h5b: return 11;
      8'h5d: return 12; 8'h28: return 13; 8'h29: return 14;
      default: return -1;
    endcase
  endfunction

  task automatic push(logic k, logic [4:0] t, logic [2:0] e, logic [OFF_W-1:0] o,
                      logic [OFF_W-1:0] l, logic [LN_W-1:0] n, logic [7:0] b);
    res_t r;
    r.kind = k; r.token_type = t; r.error_code = e; r.offset = o;
    r.length = l; r.line = n; r.bad_char = b; r.last = 1'b0;
    burst.push_back(r);
  endtask

  task automatic put_tok(logic [4:0] t, logic [OFF_W-1:0] l);
    push(K_TOKEN, t, 3'd0, tok_start, l, ln_cnt, 8'd0);
  endtask

  task automatic put_err(logic [2:0] e, logic [OFF_W-1:0] o, logic [7:0] b);
    push(K_ERROR, 5'd0, e, o, '0, ln_cnt, b);
  endtask

  task automatic step_pos(logic [7:0] c);
    if (c == 8'h0a) ln_cnt = ln_cnt + 1'b1;
    pos = pos + 1'b1;
  endtask

  // returns 1 when the byte is consumed, 0 when it must be looked at again
  task automatic lex(input logic [7:0] c, output logic done);
    logic [OFF_W-1:0] span, dpos;
    int p;
    span = pos - tok_start;
    done = 1'b1;
    case (st)
      S_IDLE: begin
        if (wsp(c)) begin
          step_pos(c);
        end else begin
          tok_start = pos;
          p = punct_idx(c);
          if (p >= 0) put_tok(5'(p), 24'd1);
          else if (c == 8'h2f) st = S_SLASH;
          else if (c == 8'h2e) st = S_DOT;
          else if (dig(c)) begin
            lead_zero = (c == 8'h30); st = S_NUM_FIRST;
          end else if (head(c)) st = S_IDENT;
          else if (c == 8'h22) st = S_Q1;
          else put_err(E_UNEXPECTED, pos, c);
          step_pos(c);
        end
      end
      S_SLASH: begin
        if (c == 8'h2f) begin
          st = S_COMMENT; step_pos(c);
        end else begin
          put_err(E_UNEXPECTED, tok_start, 8'h2f); st = S_IDLE; done = 1'b0;
        end
      end
      S_COMMENT: begin
        if (c == 8'h0a) st = S_IDLE;
        step_pos(c);
      end
      S_DOT: begin
        if (c == 8'h2e) begin
          put_tok(T_RANGE, 24'd2); st = S_IDLE; step_pos(c);
        end else if (dig(c)) begin
          st = S_FRAC; step_pos(c);
        end else begin
          put_tok(T_DOT, 24'd1); st = S_IDLE; done = 1'b0;
        end
      end
      S_NUM_FIRST: begin
        if (lead_zero && c == 8'h78) begin
          st = S_HEX_FIRST; step_pos(c);
        end else if (lead_zero && c == 8'h62) begin
          st = S_BIN_FIRST; step_pos(c);
        end else if (lead_zero && dig(c)) begin
          put_err(E_LEAD_ZERO, tok_start, 8'd0); st = S_INT; step_pos(c);
        end else begin
          st = S_INT; done = 1'b0;
        end
      end
      S_INT: begin
        if (dig(c)) step_pos(c);
        else if (c == 8'h2e) begin
          st = S_INT_DOT; step_pos(c);
        end else if (c == 8'h65 || c == 8'h45) begin
          st = S_EXP_SIGN; step_pos(c);
        end else begin
          put_tok(T_INT, span); st = S_IDLE; done = 1'b0;
        end
      end
      S_INT_DOT: begin
        if (c == 8'h2e) begin
          // integer followed by a range: split at the first dot
          dpos = pos - 1'b1;
          put_tok(T_INT, dpos - tok_start);
          push(K_TOKEN, T_RANGE, 3'd0, dpos, 24'd2, ln_cnt, 8'd0);
          st = S_IDLE; step_pos(c);
        end else begin
          st = S_FRAC; done = 1'b0;
        end
      end
      S_FRAC, S_EXP_DIGITS: begin
        if (dig(c)) step_pos(c);
        else if (st == S_FRAC && (c == 8'h65 || c == 8'h45)) begin
          st = S_EXP_SIGN; step_pos(c);
        end else begin
          put_tok(T_FLOAT, span); st = S_IDLE; done = 1'b0;
        end
      end
      S_EXP_SIGN, S_EXP_AFTER_SIGN: begin
        if (st == S_EXP_SIGN && (c == 8'h2b || c == 8'h2d)) begin
          st = S_EXP_AFTER_SIGN; step_pos(c);
        end else if (dig(c)) begin
          st = S_EXP_DIGITS; step_pos(c);
        end else begin
          put_err(E_NO_EXP, tok_start, 8'd0); put_tok(T_FLOAT, span);
          st = S_IDLE; done = 1'b0;
        end
      end
      S_HEX_FIRST, S_HEX: begin
        if (hexd(c)) begin
          st = S_HEX; step_pos(c);
        end else begin
          if (st == S_HEX_FIRST) put_err(E_NO_HEX, tok_start, 8'd0);
          put_tok(T_HEX, span); st = S_IDLE; done = 1'b0;
        end
      end
      S_BIN_FIRST, S_BIN: begin
        if (c == 8'h30 || c == 8'h31) begin
          st = S_BIN; step_pos(c);
        end else begin
          if (st == S_BIN_FIRST) put_err(E_NO_BIN, tok_start, 8'd0);
          put_tok(T_BIN, span); st = S_IDLE; done = 1'b0;
        end
      end
      S_IDENT: begin
        if (head(c) || dig(c)) step_pos(c);
        else begin
          put_tok(T_IDENT, span); st = S_IDLE; done = 1'b0;
        end
      end
      S_Q1: begin
        if (c == 8'h22) begin
          st = S_Q2; step_pos(c);
        end else begin
          st = S_STR; done = 1'b0;
        end
      end
      S_Q2: begin
        if (c == 8'h22) begin
          str_line = ln_cnt; st = S_LONG; step_pos(c);
        end else begin
          put_tok(T_STRING, 24'd2); st = S_IDLE; done = 1'b0;
        end
      end
      S_STR: begin
        if (c == 8'h22) begin
          step_pos(c); put_tok(T_STRING, pos - tok_start); st = S_IDLE;
        end else if (c == 8'h5c) begin
          st = S_STR_ESC; step_pos(c);
        end else if (c == 8'h0a) begin
          put_err(E_UNTERM_STR, tok_start, 8'd0); stopped = 1'b1;
        end else step_pos(c);
      end
      S_STR_ESC: begin
        st = S_STR;
        if (c == 8'h5c || c == 8'h6e) step_pos(c);
        else begin
          put_err(E_BAD_ESC, pos, c); done = 1'b0;
        end
      end
      default: begin
        // long string and its closing quotes
        if (c != 8'h22) st = S_LONG;
        else if (st == S_LONG) st = S_LONG_Q1;
        else if (st == S_LONG_Q1) st = S_LONG_Q2;
        else begin
          step_pos(c); put_tok(T_LONG_STRING, pos - tok_start); st = S_IDLE;
          return;
        end
        step_pos(c);
      end
    endcase
  endtask

  task automatic finish_pending();
    logic [OFF_W-1:0] span;
    span = pos - tok_start;
    case (st)
      S_SLASH: put_err(E_UNEXPECTED, tok_start, 8'h2f);
      S_DOT: put_tok(T_DOT, 24'd1);
      S_NUM_FIRST, S_INT: put_tok(T_INT, span);
      S_INT_DOT, S_FRAC, S_EXP_DIGITS: put_tok(T_FLOAT, span);
      S_EXP_SIGN, S_EXP_AFTER_SIGN: begin
        put_err(E_NO_EXP, tok_start, 8'd0); put_tok(T_FLOAT, span);
      end
      S_HEX_FIRST: begin
        put_err(E_NO_HEX, tok_start, 8'd0); put_tok(T_HEX, span);
      end
      S_HEX: put_tok(T_HEX, span);
      S_BIN_FIRST: begin
        put_err(E_NO_BIN, tok_start, 8'd0); put_tok(T_BIN, span);
      end
      S_BIN: put_tok(T_BIN, span);
      S_IDENT: put_tok(T_IDENT, span);
      S_Q1, S_STR, S_STR_ESC: put_err(E_UNTERM_STR, tok_start, 8'd0);
      S_Q2: put_tok(T_STRING, 24'd2);
      S_LONG, S_LONG_Q1, S_LONG_Q2: begin
        push(K_ERROR, 5'd0, E_UNTERM_LONG, tok_start, '0, str_line, 8'd0);
        put_tok(T_LONG_STRING, span);
      end
      default: ;
    endcase
  endtask

  task automatic clear_state();
    st = S_IDLE; ln_cnt = LN_W'(1); pos = '0; tok_start = '0;
    str_line = LN_W'(1); lead_zero = 1'b0; stopped = 1'b0;
  endtask

  task automatic predict(req_t rq);
    logic done;
    burst.delete();
    if (rq.cmd != CMD_BYTE) begin
      if (!stopped) finish_pending();
      push(K_TOKEN, T_END, 3'd0, pos, '0, ln_cnt, 8'd0);
      clear_state();
    end else if (!stopped) begin
      for (int k = 0; k < 4; k++) begin
        lex(rq.byte_req, done);
        if (done || stopped) break;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) tokens_q.push_back(burst[i]);
  endtask

  task automatic report(string what, res_t got, res_t want);
    fail_count_o++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  initial begin
    fail_count_o = 0;
    clear_state();
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (tokens_q.size() == 0) begin
          report("unexpected result", out_res_i, '0);
        end else begin
          want = tokens_q.pop_front();
          if (out_res_i.kind != want.kind) report("kind", out_res_i, want);
          else if (out_res_i.token_type != want.token_type) report("type", out_res_i, want);
          else if (out_res_i.error_code != want.error_code) report("code", out_res_i, want);
          else if (out_res_i.offset != want.offset) report("offset", out_res_i, want);
          else if (out_res_i.length != want.length) report("length", out_res_i, want);
          else if (out_res_i.line != want.line) report("line", out_res_i, want);
          else if (out_res_i.bad_char != want.bad_char) report("bad_char", out_res_i, want);
          else if (out_res_i.last != want.last) report("last", out_res_i, want);
        end
      end
      if (in_valid_i && in_ready_i) predict(in_req_i);
    end
  end

endmodule

@@ tb/schema_language_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
module schema_language_tokenizer_core_tb;
  import slt_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  req_t        in_req;
  res_t        out_res;
  int unsigned fail_count, pending;
  int          send_idle_pct, recv_idle_pct;

  schema_language_tokenizer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res)
  );

  schema_language_tokenizer_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_res_i    (out_res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: ready toggles at random on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one request; valid stays high until accepted. It drops only when the
  // next request idles first, or after the last request.
  task automatic send_req(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{cmd: cmd, byte_req: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_req(CMD_BYTE, s[i]);
  endtask

  // Fragments with random content, well-formed and malformed, mixed with raw noise.
  task automatic send_fragment();
    string pn;
    int    n;
    pn = ",=;:-#@*?{}[]()";
    case ($urandom_range(13))
      0: send_req(CMD_BYTE, pn[$urandom_range(14)]);
      1: begin
        n = $urandom_range(1, 5);
        send_req(CMD_BYTE, 8'(8'h61 + $urandom_range(25)));
        repeat (n) send_req(CMD_BYTE, 8'(8'h30 + $urandom_range(9)));
      end
      2: repeat ($urandom_range(1, 4)) send_req(CMD_BYTE, 8'(8'h30 + $urandom_range(9)));
      3: send_text($urandom_range(1) ? "0x1fA" : "0b101");
      4: send_text($urandom_range(1) ? "3.25e-7" : "12e");
      5: send_text($urandom_range(1) ? "1..4" : "..");
      6: send_text($urandom_range(1) ? "\"ab\\n\"" : "\"a\\q\"");
      7: send_text("\"\"\"x\"y\"\"\"");
      8: send_text("// note\n");
      9: send_req(CMD_BYTE, $urandom_range(1) ? 8'h20 : 8'h0a);
      10: send_text($urandom_range(1) ? "." : "/");
      11: send_text($urandom_range(1) ? "0x" : "0b2");
      12: send_text("\"open");
      default: send_req(CMD_BYTE, 8'($urandom_range(255)));
    endcase
    // spaces keep fragments apart most of the time
    if ($urandom_range(3) != 0) send_req(CMD_BYTE, 8'h20);
  endtask

  task automatic random_phase(int snd, int rcv, int items);
    int start;
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    start = 0;
    while (start < items) begin
      send_fragment();
      start += 4;
      if ($urandom_range(15) == 0) send_req(CMD_END, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    in_valid      = 1'b0;
    in_req        = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every punctuation mark, numbers, strings, edge cases.
    send_text(",=;:-#@*?{}[]()");
    send_text(" 0x 0b 007 1e+ .5 x_9 \"\"");
    send_req(CMD_BYTE, 8'hff);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_END, 8'hff);
    send_text("\"\"\"long");
    send_req(CMD_END, 8'h00);
    send_text("\"s\nzz/");
    send_req(CMD_END, 8'h5a);
    send_text("/.");
    send_req(CMD_END, 8'h00);

    random_phase(27, 46, 60);
    random_phase(46, 27, 60);
    random_phase(0, 0, 60);
    send_req(CMD_END, 8'h00);
    in_valid <= 1'b0;

    recv_idle_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS schema_language_tokenizer_core");
    end else begin
      $display("FAIL schema_language_tokenizer_core");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL schema_language_tokenizer_core");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/slt_pkg.sv
hw/rtl/slt_lexer.sv
hw/rtl/schema_language_tokenizer_core.sv
tb/schema_language_tokenizer_checker.sv
tb/schema_language_tokenizer_core_tb.sv
